[design/stepper_pulse_and_servo_pwm_generator_unit_macros.svh]
// Assertion macros for the stepper pulse and servo PWM generator.
// Used by the top level; each macro expects clk and rst_n in scope.
`ifndef STEPPER_PULSE_AND_SERVO_PWM_GENERATOR_UNIT_MACROS_SVH
`define STEPPER_PULSE_AND_SERVO_PWM_GENERATOR_UNIT_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define SPG_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spgen assertion failed");

// Consequent holds starting in the cycle after the antecedent.
`define SPG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error("spgen assertion failed");

`endif

[design/spgen_pkg.sv]
// Shared types and constants of the stepper pulse and servo PWM generator.
// No dependencies; used by every module of the block.
package spgen_pkg;

  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_START     = 3'd1,
    CMD_STOP      = 3'd2,
    CMD_TAKE      = 3'd3,
    CMD_SERVO_ON  = 3'd4,
    CMD_SERVO_OFF = 3'd5,
    CMD_SET_PULSE = 3'd6
  } cmd_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_TICK,
    OP_START,
    OP_STOP,
    OP_TAKE,
    OP_SERVO_ON,
    OP_SERVO_OFF,
    OP_SET_PULSE
  } op_t;

  typedef enum logic [2:0] {
    REG_TICK_HZ      = 3'd0,
    REG_MAX_SPEED    = 3'd1,
    REG_SERVO_MIN_US = 3'd2,
    REG_SERVO_MAX_US = 3'd3,
    REG_FRAME_TICKS  = 3'd4
  } reg_idx_t;

  localparam int CFG_W       = 16;
  localparam int CLAMP_W     = 14;
  localparam int PHASE_W     = 17;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [15:0] TICK_HZ_RST      = 16'd25000;
  localparam logic [15:0] MAX_SPEED_RST    = 16'd12500;
  localparam logic [13:0] SERVO_MIN_RST    = 14'd500;
  localparam logic [13:0] SERVO_MAX_RST    = 14'd2500;
  localparam logic [15:0] FRAME_TICKS_RST  = 16'd500;

  typedef struct packed {
    logic [15:0] tick_hz;
    logic [15:0] max_speed;
    logic [13:0] servo_min_us;
    logic [13:0] servo_max_us;
    logic [15:0] frame_ticks;
  } cfg_t;

  typedef struct packed {
    op_t                op;
    logic               ch;
    logic               start_ok;
    logic [31:0]        pulse_count;
    logic [15:0]        speed;
    logic signed [7:0]  direction;
    logic [7:0]         servo_ticks;
  } item_t;

endpackage

[design/spgen_front.sv]
// Front end: accepts input words, decodes the command and precomputes
// start checks and servo tick counts. Depends on spgen_pkg.
module spgen_front #(
  parameter int TICK_US = 40
) (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_command,
  input  logic               in_channel,
  input  logic [31:0]        in_pulse_count,
  input  logic [15:0]        in_speed,
  input  logic signed [7:0]  in_direction,
  input  logic [15:0]        in_pulse_width_us,
  input  spgen_pkg::cfg_t    cfg,
  input  logic               q_full,
  output logic               q_push,
  output spgen_pkg::item_t   q_item
);

  localparam int X_W    = spgen_pkg::CLAMP_W + 1;
  localparam int SHIFT  = X_W + $clog2(TICK_US);
  localparam longint RECIP = ((longint'(1) << SHIFT) + longint'(TICK_US) - 1) /
                             longint'(TICK_US);
  localparam int PROD_W = X_W + SHIFT + 1;

  logic [spgen_pkg::CLAMP_W-1:0] clamped;
  logic [X_W-1:0]                rounded;
  logic [SHIFT:0]                recip_c;
  logic [PROD_W-1:0]             prod;
  spgen_pkg::op_t                op;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    if (in_pulse_width_us < {2'b00, cfg.servo_min_us}) begin
      clamped = cfg.servo_min_us;
    end else if (in_pulse_width_us > {2'b00, cfg.servo_max_us}) begin
      clamped = cfg.servo_max_us;
    end else begin
      clamped = in_pulse_width_us[spgen_pkg::CLAMP_W-1:0];
    end
  end

  // Division by the tick period, rounded to nearest, through a reciprocal multiply.
  assign rounded = X_W'(clamped) + X_W'(TICK_US / 2);
  assign recip_c = (SHIFT + 1)'(RECIP);
  assign prod    = PROD_W'(rounded) * PROD_W'(recip_c);

  always_comb begin
    op = spgen_pkg::OP_NONE;
    unique case (spgen_pkg::cmd_t'(in_command))
      spgen_pkg::CMD_TICK:      op = spgen_pkg::OP_TICK;
      spgen_pkg::CMD_START:     op = spgen_pkg::OP_START;
      spgen_pkg::CMD_STOP:      op = spgen_pkg::OP_STOP;
      spgen_pkg::CMD_TAKE:      op = spgen_pkg::OP_TAKE;
      spgen_pkg::CMD_SERVO_ON:  op = spgen_pkg::OP_SERVO_ON;
      spgen_pkg::CMD_SERVO_OFF: op = spgen_pkg::OP_SERVO_OFF;
      spgen_pkg::CMD_SET_PULSE: op = spgen_pkg::OP_SET_PULSE;
      default:                  op = spgen_pkg::OP_NONE;
    endcase
  end

  always_comb begin
    q_item             = '0;
    q_item.op          = op;
    q_item.ch          = in_channel;
    q_item.start_ok    = (in_pulse_count != 32'd0) && (in_speed != 16'd0) &&
                         (in_speed <= cfg.max_speed);
    q_item.pulse_count = in_pulse_count;
    q_item.speed       = in_speed;
    q_item.direction   = in_direction;
    q_item.servo_ticks = prod[SHIFT +: 8];
  end

endmodule

[design/spgen_queue.sv]
// Short queue between the front end and the execution back end.
// Depends on spgen_pkg for the queued word type and its depth.
module spgen_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  spgen_pkg::item_t  push_item,
  output logic              full,
  input  logic              pop,
  output logic              pop_valid,
  output spgen_pkg::item_t  pop_item
);

  localparam int DEPTH = spgen_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  spgen_pkg::item_t   entries_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_item  = entries_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[design/spgen_back.sv]
// Back end: holds stepper and servo state, executes decoded words and
// drives the registered result port. Depends on spgen_pkg.
module spgen_back #(
  parameter int CHANNEL_COUNT = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  spgen_pkg::cfg_t    cfg,
  input  logic               q_valid,
  input  spgen_pkg::item_t   q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_accepted,
  output logic               out_completion,
  output logic               out_busy_res,
  output logic signed [31:0] out_position,
  output logic [1:0]         out_step_levels,
  output logic [1:0]         out_servo_levels
);

  localparam int PW    = spgen_pkg::PHASE_W;
  localparam int LVL_N = (CHANNEL_COUNT < 2) ? CHANNEL_COUNT : 2;

  logic [PW-1:0]            phase_r   [CHANNEL_COUNT];
  logic [PW-1:0]            phase_nxt [CHANNEL_COUNT];
  logic [15:0]              inc_r     [CHANNEL_COUNT];
  logic [15:0]              inc_nxt   [CHANNEL_COUNT];
  logic [31:0]              pulses_r  [CHANNEL_COUNT];
  logic [31:0]              pulses_nxt[CHANNEL_COUNT];
  logic signed [7:0]        dir_r     [CHANNEL_COUNT];
  logic signed [7:0]        dir_nxt   [CHANNEL_COUNT];
  logic [31:0]              pos_r     [CHANNEL_COUNT];
  logic [31:0]              pos_nxt   [CHANNEL_COUNT];
  logic [7:0]               sticks_r  [CHANNEL_COUNT];
  logic [7:0]               sticks_nxt[CHANNEL_COUNT];
  logic [CHANNEL_COUNT-1:0] busy_r, busy_nxt;
  logic [CHANNEL_COUNT-1:0] high_r, high_nxt;
  logic [CHANNEL_COUNT-1:0] done_r, done_nxt;
  logic [CHANNEL_COUNT-1:0] sen_r, sen_nxt;
  logic [CHANNEL_COUNT-1:0] spin_r, spin_nxt;
  logic [15:0]              frame_r, frame_nxt;

  logic [PW-1:0]            ph_sat  [CHANNEL_COUNT];
  logic [PW:0]              ph_sum  [CHANNEL_COUNT];
  logic [CHANNEL_COUNT-1:0] ph_hit;
  logic [16:0]              frame_inc;
  logic                     take, is_tick;

  logic                     out_valid_r, out_valid_nxt;
  logic                     acc_r, acc_nxt;
  logic                     comp_r, comp_nxt;
  logic                     busy_res_r, busy_res_nxt;
  logic [31:0]              pos_res_r, pos_res_nxt;
  logic [1:0]               sl_r, sl_nxt;
  logic [1:0]               vl_r, vl_nxt;

  assign take    = q_valid && (!out_valid_r || out_ready);
  assign q_pop   = take;
  assign is_tick = (q_item.op == spgen_pkg::OP_TICK);

  always_comb begin
    for (int i = 0; i < CHANNEL_COUNT; i++) begin
      ph_sum[i] = {1'b0, phase_r[i]} + (PW + 1)'(inc_r[i]);
      ph_sat[i] = ph_sum[i][PW] ? {PW{1'b1}} : ph_sum[i][PW-1:0];
      ph_hit[i] = (ph_sat[i] >= PW'(cfg.tick_hz));
    end
  end

  assign frame_inc = {1'b0, frame_r} + 17'd1;

  always_comb begin
    phase_nxt  = phase_r;
    inc_nxt    = inc_r;
    pulses_nxt = pulses_r;
    dir_nxt    = dir_r;
    pos_nxt    = pos_r;
    sticks_nxt = sticks_r;
    busy_nxt   = busy_r;
    high_nxt   = high_r;
    done_nxt   = done_r;
    sen_nxt    = sen_r;
    spin_nxt   = spin_r;
    frame_nxt  = frame_r;
    acc_nxt    = 1'b0;
    comp_nxt   = 1'b0;

    if (take && is_tick) begin
      frame_nxt = ((frame_inc >= {1'b0, cfg.frame_ticks}) || frame_inc[16]) ?
                  16'd0 : frame_inc[15:0];
    end

    for (int i = 0; i < CHANNEL_COUNT; i++) begin
      if (take && is_tick) begin
        if (busy_r[i]) begin
          phase_nxt[i] = ph_sat[i];
          if (high_r[i]) begin
            high_nxt[i]   = 1'b0;
            pos_nxt[i]    = pos_r[i] + 32'(dir_r[i]);
            pulses_nxt[i] = pulses_r[i] - 32'd1;
            if (pulses_r[i] == 32'd1) begin
              busy_nxt[i] = 1'b0;
              done_nxt[i] = 1'b1;
            end
          end else if (ph_hit[i]) begin
            phase_nxt[i] = ph_sat[i] - PW'(cfg.tick_hz);
            high_nxt[i]  = 1'b1;
          end
        end
        if (sen_r[i]) begin
          if (frame_r == 16'd0) begin
            spin_nxt[i] = 1'b1;
          end
          if (frame_r == {8'd0, sticks_r[i]}) begin
            spin_nxt[i] = 1'b0;
          end
        end
      end else if (take && (int'(q_item.ch) == i)) begin
        case (q_item.op)
          spgen_pkg::OP_START: begin
            if (q_item.start_ok && !busy_r[i]) begin
              phase_nxt[i]  = '0;
              inc_nxt[i]    = q_item.speed;
              pulses_nxt[i] = q_item.pulse_count;
              dir_nxt[i]    = q_item.direction;
              busy_nxt[i]   = 1'b1;
              high_nxt[i]   = 1'b0;
              done_nxt[i]   = 1'b0;
              acc_nxt       = 1'b1;
            end
          end
          spgen_pkg::OP_STOP: begin
            busy_nxt[i]   = 1'b0;
            high_nxt[i]   = 1'b0;
            done_nxt[i]   = 1'b0;
            pulses_nxt[i] = 32'd0;
          end
          spgen_pkg::OP_TAKE: begin
            comp_nxt    = done_r[i];
            done_nxt[i] = 1'b0;
          end
          spgen_pkg::OP_SERVO_ON: begin
            sen_nxt[i] = 1'b1;
          end
          spgen_pkg::OP_SERVO_OFF: begin
            sen_nxt[i]  = 1'b0;
            spin_nxt[i] = 1'b0;
          end
          spgen_pkg::OP_SET_PULSE: begin
            sticks_nxt[i] = q_item.servo_ticks;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    busy_res_nxt = 1'b0;
    pos_res_nxt  = '0;
    sl_nxt       = '0;
    vl_nxt       = '0;
    for (int i = 0; i < CHANNEL_COUNT; i++) begin
      if (int'(q_item.ch) == i) begin
        busy_res_nxt = busy_nxt[i];
        pos_res_nxt  = pos_nxt[i];
      end
    end
    for (int i = 0; i < LVL_N; i++) begin
      sl_nxt[i] = high_nxt[i];
      vl_nxt[i] = spin_nxt[i];
    end
  end

  always_comb begin
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        phase_r[i]  <= '0;
        inc_r[i]    <= '0;
        pulses_r[i] <= '0;
        dir_r[i]    <= '0;
        pos_r[i]    <= '0;
        sticks_r[i] <= '0;
      end
      busy_r      <= '0;
      high_r      <= '0;
      done_r      <= '0;
      sen_r       <= '0;
      spin_r      <= '0;
      frame_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      inc_r       <= inc_nxt;
      pulses_r    <= pulses_nxt;
      dir_r       <= dir_nxt;
      pos_r       <= pos_nxt;
      sticks_r    <= sticks_nxt;
      busy_r      <= busy_nxt;
      high_r      <= high_nxt;
      done_r      <= done_nxt;
      sen_r       <= sen_nxt;
      spin_r      <= spin_nxt;
      frame_r     <= frame_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      acc_r      <= acc_nxt;
      comp_r     <= comp_nxt;
      busy_res_r <= busy_res_nxt;
      pos_res_r  <= pos_res_nxt;
      sl_r       <= sl_nxt;
      vl_r       <= vl_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = acc_r;
  assign out_completion   = comp_r;
  assign out_busy_res     = busy_res_r;
  assign out_position     = pos_res_r;
  assign out_step_levels  = sl_r;
  assign out_servo_levels = vl_r;

endmodule

[design/stepper_pulse_and_servo_pwm_generator_unit.sv]
// Top level of the stepper pulse and servo PWM generator: configuration
// registers, front end, queue and back end. Depends on spgen_pkg, the
// spgen_* modules and the macros header.
//
//   Channel   Direction  Handshake          Contents
//   in_*      input      in_valid/in_ready  command word with stepper/servo fields
//   out_*     output     out_valid/out_ready one result word per command word
//   cfg_*     input      cfg_we             register index and write data
//
// One word per cycle is accepted while the queue is not full; each word is
// held in the front-end queue and its result in the back-end output register.
// The back end executes one word per cycle, unless the output stalls.
// A two-entry queue and the output register absorb output stalls; in_ready
// drops only when the queue is full. Reset is synchronous and clears all
// channel state and restores the register defaults.
module stepper_pulse_and_servo_pwm_generator_unit #(
  parameter int CHANNEL_COUNT = 2,
  parameter int TICK_US       = 40
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_command,
  input  logic               in_channel,
  input  logic [31:0]        in_pulse_count,
  input  logic [15:0]        in_speed,
  input  logic signed [7:0]  in_direction,
  input  logic [15:0]        in_pulse_width_us,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_accepted,
  output logic               out_completion,
  output logic               out_busy_res,
  output logic signed [31:0] out_position,
  output logic [1:0]         out_step_levels,
  output logic [1:0]         out_servo_levels,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

`include "stepper_pulse_and_servo_pwm_generator_unit_macros.svh"

  spgen_pkg::cfg_t  cfg_r, cfg_nxt;
  spgen_pkg::item_t push_item, pop_item;
  logic             q_full, q_push, q_pop, q_valid;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (spgen_pkg::reg_idx_t'(cfg_index))
        spgen_pkg::REG_TICK_HZ:      cfg_nxt.tick_hz      = cfg_wdata;
        spgen_pkg::REG_MAX_SPEED:    cfg_nxt.max_speed    = cfg_wdata;
        spgen_pkg::REG_SERVO_MIN_US: cfg_nxt.servo_min_us = cfg_wdata[13:0];
        spgen_pkg::REG_SERVO_MAX_US: cfg_nxt.servo_max_us = cfg_wdata[13:0];
        spgen_pkg::REG_FRAME_TICKS:  cfg_nxt.frame_ticks  = cfg_wdata;
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tick_hz      <= spgen_pkg::TICK_HZ_RST;
      cfg_r.max_speed    <= spgen_pkg::MAX_SPEED_RST;
      cfg_r.servo_min_us <= spgen_pkg::SERVO_MIN_RST;
      cfg_r.servo_max_us <= spgen_pkg::SERVO_MAX_RST;
      cfg_r.frame_ticks  <= spgen_pkg::FRAME_TICKS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  spgen_front #(
    .TICK_US (TICK_US)
  ) u_front (
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_channel        (in_channel),
    .in_pulse_count    (in_pulse_count),
    .in_speed          (in_speed),
    .in_direction      (in_direction),
    .in_pulse_width_us (in_pulse_width_us),
    .cfg               (cfg_r),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_item            (push_item)
  );

  spgen_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (pop_item)
  );

  spgen_back #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_valid          (q_valid),
    .q_item           (pop_item),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_accepted     (out_accepted),
    .out_completion   (out_completion),
    .out_busy_res     (out_busy_res),
    .out_position     (out_position),
    .out_step_levels  (out_step_levels),
    .out_servo_levels (out_servo_levels)
  );

  // An accepted start always leaves its stepper busy.
  `SPG_ASSERT_SAME(a_start_busy, out_valid && out_accepted, out_busy_res)
  // A pending completion only exists on an idle stepper.
  `SPG_ASSERT_SAME(a_done_idle, out_valid && out_completion, !out_busy_res)
  // With nothing in flight a new word passes through the queue and then the output register.
  `SPG_ASSERT_NEXT(a_latency, in_valid && in_ready && !q_valid && !out_valid,
                   ##1 out_valid)

endmodule
